>>> hw/rtl/sce_pkg.sv
// Shared types and constants for the channel effects tick block.
// Used by sce_csr, sce_core and sound_channel_effects_tick; no dependencies.
package sce_pkg;

   typedef enum logic [3:0] {
      OP_TICK       = 4'd0,
      OP_NOTE_ON    = 4'd1,
      OP_PERIOD     = 4'd2,
      OP_PITCH_BEND = 4'd3,
      OP_FADE       = 4'd4,
      OP_ARP        = 4'd5,
      OP_SET_VOL    = 4'd6,
      OP_SET_GLIDE  = 4'd7,
      OP_OFF        = 4'd8
   } sce_op_type;

   typedef enum logic [1:0] {
      REG_DETUNE  = 2'd0,
      REG_FLOOR   = 2'd1,
      REG_CEILING = 2'd2
   } sce_reg_type;

   localparam int AddrWidth   = 4;
   localparam int ReqDataBits = 72;
   localparam int RspDataBits = 40;

   localparam logic [14:0] FloorReset   = 15'd0;
   localparam logic [14:0] CeilingReset = 15'd32767;

   localparam logic signed [13:0] OffsetMax = 14'sd4095;
   localparam logic signed [13:0] OffsetMin = -14'sd4095;
   localparam logic [8:0]         VolumeMax = 9'd15;

   typedef struct packed {
      logic signed [7:0] detune;
      logic [14:0]       pitch_floor;
      logic [14:0]       pitch_ceiling;
   } sce_cfg_type;

   typedef struct packed {
      logic [3:0]         opcode;
      logic [6:0]         note;
      logic               has_instrument;
      logic               direction;
      logic [7:0]         wait_req;
      logic [14:0]        rate;
      logic signed [15:0] pitch_step;
      logic [3:0]         arp_length;
      logic [15:0]        arp_pattern;
      logic [3:0]         volume_value;
   } sce_item_type;

   typedef struct packed {
      logic signed [15:0] pitch_out;
      logic signed [12:0] period_offset_out;
      logic [3:0]         volume_out;
      logic [3:0]         arp_out;
      logic               attack;
   } sce_result_type;

endpackage

>>> hw/rtl/sce_csr.sv
// Configuration registers (detune, pitch floor, pitch ceiling) on an APB-style port.
// Depends on sce_pkg.
module sce_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sce_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready,
   output sce_pkg::sce_cfg_type        cfg
);
   import sce_pkg::*;

   sce_cfg_type cfg_ff, cfg_in;
   logic        wr_en;
   sce_reg_type wr_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign wr_sel     = sce_reg_type'(csr_paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_sel)
            REG_DETUNE:  cfg_in.detune        = csr_pwdata[7:0];
            REG_FLOOR:   cfg_in.pitch_floor   = csr_pwdata[14:0];
            REG_CEILING: cfg_in.pitch_ceiling = csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (wr_sel)
         REG_DETUNE:  csr_prdata = {24'd0, cfg_ff.detune};
         REG_FLOOR:   csr_prdata = {17'd0, cfg_ff.pitch_floor};
         REG_CEILING: csr_prdata = {17'd0, cfg_ff.pitch_ceiling};
         default:     csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detune        <= 8'sd0;
         cfg_ff.pitch_floor   <= FloorReset;
         cfg_ff.pitch_ceiling <= CeilingReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/sce_core.sv
// Channel effect state and the combinational step for one command or tick.
// Depends on sce_pkg.
module sce_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  sce_pkg::sce_item_type   item,
   input  sce_pkg::sce_cfg_type    cfg,
   output sce_pkg::sce_result_type result
);
   import sce_pkg::*;

   logic [2:0]         flags_ff, flags_in;
   logic signed [15:0] pitch_ff, pitch_in;
   logic signed [15:0] delta_ff, delta_in;
   logic [7:0]         pwait_ff, pwait_in;
   logic [7:0]         ptimer_ff, ptimer_in;
   logic signed [15:0] low_ff, low_in;
   logic signed [15:0] high_ff, high_in;
   logic [14:0]        glide_ff, glide_in;
   logic [14:0]        prate_ff, prate_in;
   logic [3:0]         pfrac_ff, pfrac_in;
   logic               pdown_ff, pdown_in;
   logic signed [12:0] poff_ff, poff_in;
   logic [14:0]        frate_ff, frate_in;
   logic [6:0]         ffrac_ff, ffrac_in;
   logic               fout_ff, fout_in;
   logic [3:0]         vol_ff, vol_in;
   logic [3:0]         arpv_ff, arpv_in;
   logic [15:0]        arpd_ff, arpd_in;
   logic [3:0]         arpl_ff, arpl_in;
   logic [7:0]         arpw_ff, arpw_in;
   logic [7:0]         arpt_ff, arpt_in;

   logic [15:0]        pacc, facc, arp_sum;
   logic signed [13:0] pstep, psum;
   logic [8:0]         fstep, fsum;
   logic signed [15:0] pnew, floor_s, ceil_s, target_s;
   logic [15:0]        target;
   logic               attack;

   localparam logic [2:0] FlagFade   = 3'b001;
   localparam logic [2:0] FlagPeriod = 3'b010;
   localparam logic [2:0] FlagPitch  = 3'b100;

   assign floor_s  = $signed({1'b0, cfg.pitch_floor});
   assign ceil_s   = $signed({1'b0, cfg.pitch_ceiling});
   assign target   = {1'b0, item.note, 8'd0} + {{8{cfg.detune[7]}}, cfg.detune};
   assign target_s = $signed(target);
   assign pacc     = {1'b0, prate_ff} + {12'd0, pfrac_ff};
   assign pstep    = $signed({2'b00, pacc[15:4]});
   assign facc     = {1'b0, frate_ff} + {9'd0, ffrac_ff};
   assign fstep    = facc[15:7];
   assign arp_sum  = arpd_ff + {12'd0, arpd_ff[15:12]};

   always_comb begin
      flags_in  = flags_ff;
      pitch_in  = pitch_ff;
      delta_in  = delta_ff;
      pwait_in  = pwait_ff;
      ptimer_in = ptimer_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      glide_in  = glide_ff;
      prate_in  = prate_ff;
      pfrac_in  = pfrac_ff;
      pdown_in  = pdown_ff;
      poff_in   = poff_ff;
      frate_in  = frate_ff;
      ffrac_in  = ffrac_ff;
      fout_in   = fout_ff;
      vol_in    = vol_ff;
      arpv_in   = arpv_ff;
      arpd_in   = arpd_ff;
      arpl_in   = arpl_ff;
      arpw_in   = arpw_ff;
      arpt_in   = arpt_ff;
      psum      = 14'sd0;
      fsum      = 9'd0;
      pnew      = pitch_ff;
      attack    = 1'b0;

      unique case (sce_op_type'(item.opcode))
         OP_TICK: begin
            if (!pitch_ff[15]) begin
               if (prate_ff != 15'd0) begin
                  pfrac_in = pacc[3:0];
                  if (!pdown_ff) begin
                     psum    = {poff_ff[12], poff_ff} + pstep;
                     poff_in = (psum > OffsetMax) ? OffsetMax[12:0] : psum[12:0];
                  end else begin
                     psum    = {poff_ff[12], poff_ff} - pstep;
                     poff_in = (psum < OffsetMin) ? OffsetMin[12:0] : psum[12:0];
                  end
               end
               if (delta_ff != 16'sd0) begin
                  if (ptimer_ff != 8'd0) begin
                     ptimer_in = ptimer_ff - 8'd1;
                  end else begin
                     ptimer_in = pwait_ff;
                     pnew      = pitch_ff + delta_ff;
                     if (pnew <= low_ff) begin
                        pnew     = low_ff;
                        low_in   = floor_s;
                        delta_in = 16'sd0;
                     end
                     if (high_ff <= pnew) begin
                        pnew     = high_ff;
                        high_in  = ceil_s;
                        delta_in = 16'sd0;
                     end
                     pitch_in = pnew;
                  end
               end
               if (frate_ff != 15'd0) begin
                  ffrac_in = facc[6:0];
                  if (!fout_ff) begin
                     fsum   = {5'd0, vol_ff} + fstep;
                     vol_in = (fsum > VolumeMax) ? 4'd15 : fsum[3:0];
                  end else begin
                     fsum   = {5'd0, vol_ff} - fstep;
                     vol_in = ({5'd0, vol_ff} <= fstep) ? 4'd0 : fsum[3:0];
                  end
               end
               if (arpd_ff != 16'd0) begin
                  if (arpt_ff != 8'd0) begin
                     arpt_in = arpt_ff - 8'd1;
                  end else begin
                     arpt_in = arpw_ff;
                     arpv_in = arpd_ff[15:12];
                     if (arpl_ff == 4'd4) begin
                        arpd_in = {arpd_ff[11:0], arpd_ff[15:12]};
                     end else if (arpl_ff == 4'd3) begin
                        arpd_in = {arp_sum[11:0], 4'd0};
                     end
                  end
               end
            end
         end
         OP_NOTE_ON: begin
            poff_in  = 13'sd0;
            flags_in = 3'b000;
            if ((flags_ff & FlagFade) == 3'b000) frate_in = 15'd0;
            if ((flags_ff & FlagPeriod) == 3'b000) prate_in = 15'd0;
            if ((flags_ff & FlagPitch) == 3'b000) delta_in = 16'sd0;
            if (!pitch_ff[15] && glide_ff != 15'd0) begin
               if (target != $unsigned(pitch_ff)) begin
                  pwait_in  = 8'd0;
                  ptimer_in = 8'd0;
                  flags_in  = FlagPitch;
                  if (target < $unsigned(pitch_ff)) begin
                     delta_in = -$signed({1'b0, glide_ff});
                     low_in   = target_s;
                     high_in  = ceil_s;
                  end else begin
                     delta_in = $signed({1'b0, glide_ff});
                     low_in   = floor_s;
                     high_in  = target_s;
                  end
               end
               glide_in = 15'd0;
            end else begin
               pitch_in = target_s;
               attack   = item.has_instrument;
            end
         end
         OP_PERIOD: begin
            prate_in = item.rate;
            pfrac_in = 4'd0;
            pdown_in = item.direction;
            flags_in = flags_ff | FlagPeriod;
         end
         OP_PITCH_BEND: begin
            pwait_in  = item.wait_req;
            ptimer_in = 8'd0;
            delta_in  = item.pitch_step;
            flags_in  = flags_ff | FlagPitch;
            low_in    = floor_s;
            high_in   = ceil_s;
         end
         OP_FADE: begin
            frate_in = item.rate;
            ffrac_in = 7'd0;
            fout_in  = item.direction;
            flags_in = flags_ff | FlagFade;
         end
         OP_ARP: begin
            arpw_in = item.wait_req;
            arpt_in = 8'd0;
            arpl_in = item.arp_length;
            arpd_in = item.arp_pattern;
         end
         OP_SET_VOL:   vol_in   = item.volume_value;
         OP_SET_GLIDE: glide_in = item.rate;
         OP_OFF:       pitch_in = -16'sd1;
         default: ;
      endcase
   end

   assign result.pitch_out         = pitch_in;
   assign result.period_offset_out = poff_in;
   assign result.volume_out        = vol_in;
   assign result.arp_out           = arpv_in;
   assign result.attack            = attack;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff  <= 3'b000;
         pitch_ff  <= -16'sd1;
         delta_ff  <= 16'sd0;
         pwait_ff  <= 8'd0;
         ptimer_ff <= 8'd0;
         low_ff    <= $signed({1'b0, FloorReset});
         high_ff   <= $signed({1'b0, CeilingReset});
         glide_ff  <= 15'd0;
         prate_ff  <= 15'd0;
         pfrac_ff  <= 4'd0;
         pdown_ff  <= 1'b0;
         poff_ff   <= 13'sd0;
         frate_ff  <= 15'd0;
         ffrac_ff  <= 7'd0;
         fout_ff   <= 1'b0;
         vol_ff    <= 4'd0;
         arpv_ff   <= 4'd0;
         arpd_ff   <= 16'd0;
         arpl_ff   <= 4'd0;
         arpw_ff   <= 8'd0;
         arpt_ff   <= 8'd0;
      end else if (fire) begin
         flags_ff  <= flags_in;
         pitch_ff  <= pitch_in;
         delta_ff  <= delta_in;
         pwait_ff  <= pwait_in;
         ptimer_ff <= ptimer_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
         glide_ff  <= glide_in;
         prate_ff  <= prate_in;
         pfrac_ff  <= pfrac_in;
         pdown_ff  <= pdown_in;
         poff_ff   <= poff_in;
         frate_ff  <= frate_in;
         ffrac_ff  <= ffrac_in;
         fout_ff   <= fout_in;
         vol_ff    <= vol_in;
         arpv_ff   <= arpv_in;
         arpd_ff   <= arpd_in;
         arpl_ff   <= arpl_in;
         arpw_ff   <= arpw_in;
         arpt_ff   <= arpt_in;
      end
   end

endmodule

>>> hw/rtl/sound_channel_effects_tick.sv
// Top level of the channel effects tick block: input word register, core, result register.
// Depends on sce_pkg, sce_csr and sce_core.
//
//   port group | direction | carries
//   req_       | in        | one command or tick word per handshake
//   rsp_       | out       | channel state after each word
//   csr_       | in/out    | detune, pitch floor, pitch ceiling
//
// One word per cycle sustained while rsp_ is ready; a result is registered before rsp_.
// The effect state update is a single pass of logic between the input and result registers.
// Synchronous reset; bounds return to the reset floor and ceiling, pitch reads as off.
// A stalled rsp_ holds the result; one more word waits in the input register, then
// req_tready drops until rsp_ drains.
module sound_channel_effects_tick (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // note, has_instrument, direction, wait_req, rate, pitch_step, arp_length,
   // arp_pattern, volume_value (lowest first)
   input  logic [sce_pkg::ReqDataBits-1:0] req_tdata,
   // opcode
   input  logic [3:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // pitch_out, period_offset_out, volume_out, arp_out, attack, 2 zero bits (lowest first)
   output logic [sce_pkg::RspDataBits-1:0] rsp_tdata,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sce_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import sce_pkg::*;

   logic           in_valid_ff;
   sce_item_type   item_ff, item_in;
   logic           out_valid_ff;
   sce_result_type result_ff, result;
   sce_cfg_type    cfg;
   logic           fire;

   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   assign item_in.opcode         = req_tuser;
   assign item_in.note           = req_tdata[6:0];
   assign item_in.has_instrument = req_tdata[7];
   assign item_in.direction      = req_tdata[8];
   assign item_in.wait_req       = req_tdata[16:9];
   assign item_in.rate           = req_tdata[31:17];
   assign item_in.pitch_step     = req_tdata[47:32];
   assign item_in.arp_length     = req_tdata[51:48];
   assign item_in.arp_pattern    = req_tdata[67:52];
   assign item_in.volume_value   = req_tdata[71:68];

   sce_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sce_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) item_ff <= item_in;
      if (fire) result_ff <= result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, result_ff.attack, result_ff.arp_out, result_ff.volume_out,
                        result_ff.period_offset_out, result_ff.pitch_out};

endmodule

>>> tb/sound_channel_effects_tick_test.sv
// Self-checking bench for sound_channel_effects_tick: a directed opening, then random words
// under several register settings, checked against an in-bench model of the effect engine.
// Depends on sce_pkg and the RTL only.
module sound_channel_effects_tick_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sce_pkg::*;

   localparam int ClockPeriod    = 8;
   localparam int ResetCycles    = 12;
   localparam int SettleCycles   = 4;
   localparam int CycleLimit     = 200000;
   localparam int LongHoldAt     = 60;
   localparam int LongHoldCycles = 300;
   localparam int PhaseWords     = 150;
   localparam int FxFade   = 0;
   localparam int FxPeriod = 1;
   localparam int FxPitch  = 2;
   localparam logic [3:0] OpUnusedLow  = 4'd9;
   localparam logic [3:0] OpUnusedHigh = 4'd15;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata = '0;
   logic [3:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [AddrWidth-1:0]   csr_paddr = '0;
   logic [31:0]            csr_pwdata = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   sound_channel_effects_tick uut (.*);

   always #(ClockPeriod / 2) clock = ~clock;

   // channel model state
   logic [2:0]         armed_fx;
   logic signed [15:0] ch_pitch, bend_step, bend_lo, bend_hi;
   logic [7:0]         bend_wait, bend_timer, arp_gap, arp_count;
   logic [14:0]        glide_amt, per_rate, fade_rate;
   logic [3:0]         per_frac, ch_volume, arp_now, arp_len;
   logic               per_down, fade_down;
   logic signed [12:0] per_offset;
   logic [6:0]         fade_frac;
   logic [15:0]        arp_seq;
   logic signed [7:0]  cfg_detune;
   logic [14:0]        cfg_floor, cfg_ceiling;

   sce_item_type   pending_words[$];
   sce_result_type expected_states[$];

   int error_count = 0;
   int results_checked = 0;
   int words_sent = 0;
   int reg_writes = 0;
   int settings_used = 0;
   int cycle_count = 0;
   int gap_left = 0;
   int burst_left = 0;
   int rx_cycle = 0;
   int hold_left = 0;
   logic long_hold_done = 1'b0;

   function automatic void arm_bend(logic [7:0] wt, logic signed [15:0] st);
      bend_wait  = wt;
      bend_timer = '0;
      bend_step  = st;
      armed_fx[FxPitch] = 1'b1;
      bend_lo = $signed({1'b0, cfg_floor});
      bend_hi = $signed({1'b0, cfg_ceiling});
   endfunction

   function automatic sce_result_type step_channel(sce_item_type w);
      sce_result_type res;
      int             acc, sum;
      logic [2:0]     was_armed;
      logic [15:0]    target, arp_sum;
      logic           attack_now;
      attack_now = 1'b0;
      case (w.opcode)
         OP_TICK: begin
            if (!ch_pitch[15]) begin
               if (per_rate != 0) begin
                  acc = int'(per_frac) + int'(per_rate);
                  per_frac = 4'(acc & 15);
                  sum = int'(per_offset) + (per_down ? -(acc >> 4) : (acc >> 4));
                  if (sum > 4095) sum = 4095;
                  if (sum < -4095) sum = -4095;
                  per_offset = 13'(sum);
               end
               if (bend_step != 0) begin
                  if (bend_timer != 0) begin
                     bend_timer = bend_timer - 8'd1;
                  end else begin
                     bend_timer = bend_wait;
                     ch_pitch = ch_pitch + bend_step;
                     if (ch_pitch <= bend_lo) begin
                        ch_pitch  = bend_lo;
                        bend_lo   = $signed({1'b0, cfg_floor});
                        bend_step = '0;
                     end
                     if (bend_hi <= ch_pitch) begin
                        ch_pitch  = bend_hi;
                        bend_hi   = $signed({1'b0, cfg_ceiling});
                        bend_step = '0;
                     end
                  end
               end
               if (fade_rate != 0) begin
                  acc = int'(fade_frac) + int'(fade_rate);
                  fade_frac = 7'(acc & 127);
                  sum = int'(ch_volume) + (fade_down ? -(acc >> 7) : (acc >> 7));
                  if (sum > 15) sum = 15;
                  if (sum < 0) sum = 0;
                  ch_volume = 4'(sum);
               end
               if (arp_seq != 0) begin
                  if (arp_count != 0) begin
                     arp_count = arp_count - 8'd1;
                  end else begin
                     arp_count = arp_gap;
                     arp_now = arp_seq[15:12];
                     if (arp_len == 4'd4) begin
                        arp_seq = {arp_seq[11:0], arp_now};
                     end else if (arp_len == 4'd3) begin
                        arp_sum = arp_seq + {12'd0, arp_now};
                        arp_seq = {arp_sum[11:0], 4'd0};
                     end
                  end
               end
            end
         end
         OP_NOTE_ON: begin
            was_armed  = armed_fx;
            per_offset = '0;
            armed_fx   = '0;
            if (!was_armed[FxFade]) fade_rate = '0;
            if (!was_armed[FxPeriod]) per_rate = '0;
            if (!was_armed[FxPitch]) bend_step = '0;
            target = {1'b0, w.note, 8'd0} + {{8{cfg_detune[7]}}, cfg_detune};
            if (!ch_pitch[15] && glide_amt != 0) begin
               if (target < $unsigned(ch_pitch)) begin
                  arm_bend(8'd0, -$signed({1'b0, glide_amt}));
                  bend_lo = $signed(target);
               end else if ($unsigned(ch_pitch) < target) begin
                  arm_bend(8'd0, $signed({1'b0, glide_amt}));
                  bend_hi = $signed(target);
               end
               glide_amt = '0;
            end else begin
               ch_pitch   = $signed(target);
               attack_now = w.has_instrument;
            end
         end
         OP_PERIOD: begin
            per_rate = w.rate;
            per_frac = '0;
            per_down = w.direction;
            armed_fx[FxPeriod] = 1'b1;
         end
         OP_PITCH_BEND: arm_bend(w.wait_req, w.pitch_step);
         OP_FADE: begin
            fade_rate = w.rate;
            fade_frac = '0;
            fade_down = w.direction;
            armed_fx[FxFade] = 1'b1;
         end
         OP_ARP: begin
            arp_gap   = w.wait_req;
            arp_count = '0;
            arp_len   = w.arp_length;
            arp_seq   = w.arp_pattern;
         end
         OP_SET_VOL: ch_volume = w.volume_value;
         OP_SET_GLIDE: glide_amt = w.rate;
         OP_OFF: ch_pitch = -16'sd1;
         default: ;
      endcase
      res.pitch_out         = ch_pitch;
      res.period_offset_out = per_offset;
      res.volume_out        = ch_volume;
      res.arp_out           = arp_now;
      res.attack            = attack_now;
      return res;
   endfunction

   function automatic sce_item_type make_word(logic [3:0] op, logic [6:0] nt, logic inst,
                                              logic dir, logic [7:0] wt, logic [14:0] rt,
                                              logic signed [15:0] st, logic [3:0] al,
                                              logic [15:0] ap, logic [3:0] vl);
      sce_item_type w;
      w.opcode = op;
      w.note = nt;
      w.has_instrument = inst;
      w.direction = dir;
      w.wait_req = wt;
      w.rate = rt;
      w.pitch_step = st;
      w.arp_length = al;
      w.arp_pattern = ap;
      w.volume_value = vl;
      return w;
   endfunction

   task automatic queue_random(int count);
      sce_item_type w;
      int           pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         w.note = 7'($urandom_range(0, 127));
         w.has_instrument = 1'($urandom_range(0, 1));
         w.direction = 1'($urandom_range(0, 1));
         w.wait_req = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 3));
         case ($urandom_range(0, 3))
            0: w.rate = 15'($urandom_range(0, 40));
            1: w.rate = 15'($urandom_range(0, 400));
            2: w.rate = 15'($urandom_range(0, 32767));
            default: w.rate = 15'($urandom_range(1, 2000));
         endcase
         w.pitch_step = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 600)) - 16'sd300;
         w.arp_length = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(3, 4));
         w.arp_pattern = 16'($urandom_range(0, 65535));
         w.volume_value = 4'($urandom_range(0, 15));
         if (pick < 40)      w.opcode = OP_TICK;
         else if (pick < 52) w.opcode = OP_NOTE_ON;
         else if (pick < 59) w.opcode = OP_PERIOD;
         else if (pick < 66) w.opcode = OP_PITCH_BEND;
         else if (pick < 73) w.opcode = OP_FADE;
         else if (pick < 80) w.opcode = OP_ARP;
         else if (pick < 86) w.opcode = OP_SET_VOL;
         else if (pick < 92) w.opcode = OP_SET_GLIDE;
         else if (pick < 96) w.opcode = OP_OFF;
         else                w.opcode = 4'($urandom_range(OpUnusedLow, OpUnusedHigh));
         pending_words.push_back(w);
      end
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_tvalid || expected_states.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(sce_reg_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // register takes the value at this edge
      case (idx)
         REG_DETUNE:  cfg_detune  = value[7:0];
         REG_FLOOR:   cfg_floor   = value[14:0];
         REG_CEILING: cfg_ceiling = value[14:0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      reg_writes++;
   endtask

   task automatic apply_settings(logic signed [7:0] det, logic [14:0] fl, logic [14:0] ce);
      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      write_reg(REG_DETUNE, {{24{det[7]}}, det});
      write_reg(REG_FLOOR, {17'd0, fl});
      write_reg(REG_CEILING, {17'd0, ce});
      settings_used++;
   endtask

   task automatic check_field(string label, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         error_count++;
      end
   endtask

   // sender: bursts of random length with random gaps
   always @(posedge clock) begin : drive
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_states.push_back(step_channel(pending_words[0]));
            void'(pending_words.pop_front());
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_words.size() > 0) begin
               offer = 1'b1;
               req_tdata <= {pending_words[0].volume_value, pending_words[0].arp_pattern,
                             pending_words[0].arp_length, pending_words[0].pitch_step,
                             pending_words[0].rate, pending_words[0].wait_req,
                             pending_words[0].direction, pending_words[0].has_instrument,
                             pending_words[0].note};
               req_tuser <= pending_words[0].opcode;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
               end
            end
            req_tvalid <= offer;
         end
      end
   end

   // receiver: own stall pattern plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle++;
         if (!long_hold_done && results_checked >= LongHoldAt) begin
            long_hold_done = 1'b1;
            hold_left = LongHoldCycles;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case ((rx_cycle >> 8) % 4)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= (rx_cycle % 5 != 2);
               default: rsp_tready <= ($urandom_range(0, 1) == 1);
            endcase
         end
      end
   end

   always @(posedge clock) begin : watch
      sce_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pitch_out         = rsp_tdata[15:0];
         got.period_offset_out = rsp_tdata[28:16];
         got.volume_out        = rsp_tdata[32:29];
         got.arp_out           = rsp_tdata[36:33];
         got.attack            = rsp_tdata[37];
         if (expected_states.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_states.pop_front();
            check_field("pitch", int'(want.pitch_out), int'(got.pitch_out));
            check_field("period offset", int'(want.period_offset_out),
                        int'(got.period_offset_out));
            check_field("volume", int'(want.volume_out), int'(got.volume_out));
            check_field("arpeggio", int'(want.arp_out), int'(got.arp_out));
            check_field("attack", int'(want.attack), int'(got.attack));
            results_checked <= results_checked + 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("%0t: timed out with %0d results outstanding", $time,
                  expected_states.size());
         $display("sound_channel_effects_tick test failed");
         $finish;
      end
   end

   initial begin
      cfg_detune = '0;
      cfg_floor = FloorReset;
      cfg_ceiling = CeilingReset;
      armed_fx = '0;
      ch_pitch = -16'sd1;
      bend_step = '0;
      bend_wait = '0;
      bend_timer = '0;
      bend_lo = $signed({1'b0, FloorReset});
      bend_hi = $signed({1'b0, CeilingReset});
      glide_amt = '0;
      per_rate = '0;
      per_frac = '0;
      per_down = 1'b0;
      per_offset = '0;
      fade_rate = '0;
      fade_frac = '0;
      fade_down = 1'b0;
      ch_volume = '0;
      arp_now = '0;
      arp_seq = '0;
      arp_len = '0;
      arp_gap = '0;
      arp_count = '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      apply_settings(8'sd0, FloorReset, CeilingReset);
      // opening: tick while off, note extremes, saturating and clamping effects
      pending_words.push_back(make_word(OP_TICK, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_NOTE_ON, 7'd0, 1'b1, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_SET_VOL, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd15));
      pending_words.push_back(make_word(OP_PERIOD, 7'd0, 1'b0, 1'b0, 8'd0, 15'd32767,
                                        16'sd0, 4'd0, 16'h0, 4'd0));
      repeat (2) pending_words.push_back(make_word(OP_TICK, 7'd127, 1'b1, 1'b1, 8'd255,
                                        15'd32767, -16'sd1, 4'd15, 16'hffff, 4'd15));
      pending_words.push_back(make_word(OP_PERIOD, 7'd0, 1'b0, 1'b1, 8'd0, 15'd17, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_TICK, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_FADE, 7'd0, 1'b0, 1'b1, 8'd0, 15'd32767, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_TICK, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_FADE, 7'd0, 1'b0, 1'b0, 8'd0, 15'd200, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      repeat (2) pending_words.push_back(make_word(OP_TICK, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0,
                                        16'sd0, 4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_NOTE_ON, 7'd127, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      // pitch bend wrapping past the ceiling, then a negative step with a wait
      pending_words.push_back(make_word(OP_PITCH_BEND, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0,
                                        16'sd32767, 4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_TICK, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_NOTE_ON, 7'd100, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_PITCH_BEND, 7'd0, 1'b0, 1'b0, 8'd2, 15'd0,
                                        -16'sd32768, 4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_TICK, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      // arpeggio: rotate by four, by three, and a length that does not rotate
      pending_words.push_back(make_word(OP_NOTE_ON, 7'd64, 1'b1, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_ARP, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd4, 16'hf5a1, 4'd0));
      pending_words.push_back(make_word(OP_TICK, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_ARP, 7'd0, 1'b0, 1'b0, 8'd1, 15'd0, 16'sd0,
                                        4'd3, 16'h1234, 4'd0));
      repeat (3) pending_words.push_back(make_word(OP_TICK, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0,
                                        16'sd0, 4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_ARP, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd15, 16'h8000, 4'd0));
      pending_words.push_back(make_word(OP_TICK, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      // glide down, then a glide to the pitch already held
      pending_words.push_back(make_word(OP_SET_GLIDE, 7'd0, 1'b0, 1'b0, 8'd0, 15'd32767,
                                        16'sd0, 4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_NOTE_ON, 7'd10, 1'b1, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_TICK, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_SET_GLIDE, 7'd0, 1'b0, 1'b0, 8'd0, 15'd5, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_NOTE_ON, 7'd10, 1'b1, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OpUnusedLow, 7'd127, 1'b1, 1'b1, 8'd255, 15'd32767,
                                        -16'sd1, 4'd15, 16'hffff, 4'd15));
      pending_words.push_back(make_word(OpUnusedHigh, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_SET_VOL, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_OFF, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      pending_words.push_back(make_word(OP_TICK, 7'd0, 1'b0, 1'b0, 8'd0, 15'd0, 16'sd0,
                                        4'd0, 16'h0, 4'd0));
      queue_random(PhaseWords);

      apply_settings(-8'sd128, 15'd0, 15'd32767);
      queue_random(PhaseWords);
      apply_settings(8'sd127, 15'd32767, 15'd0);
      queue_random(PhaseWords);
      apply_settings(8'($urandom_range(0, 255)), 15'($urandom_range(0, 16383)),
                     15'($urandom_range(16384, 32767)));
      queue_random(PhaseWords);
      apply_settings(-8'sd1, 15'd32767, 15'd32767);
      queue_random(PhaseWords);

      wait_drained();
      repeat (SettleCycles * 2) @(posedge clock);
      $display("Run covered %0d words and %0d checked results", words_sent, results_checked);
      $display("under %0d register settings (%0d writes), %0d mismatches", settings_used,
               reg_writes, error_count);
      if (error_count == 0) begin
         $display("sound_channel_effects_tick test passed");
      end else begin
         $display("sound_channel_effects_tick test failed");
      end
      $finish;
   end

endmodule
